>>> rtl/core/sawrq_pkg.sv
// sawrq_pkg: shared types, constants and field positions for the
// stop-and-wait request queue. No dependencies.
`timescale 1ns / 1ps

package sawrq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int NODE_COUNT  = 8;

    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int NODE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int ENTRY_W     = KIND_W + NODE_W;
    localparam int TIMEOUT_W   = 14;
    localparam int CD_W        = TIMEOUT_W + 1;
    localparam int VALUE_W     = 32;
    localparam int HALF_W      = 16;
    localparam int ALIVE_OUT_W = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);
    localparam logic [CD_W-1:0]      AFTER_TIMEOUT = CD_W'(255);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ENQ   = 2'd1,
        ACT_REPLY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMPASS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BATTERY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LATITUDE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LONGITUDE = 3'd4;

    // input item: tuser carries the action, tdata the rest
    localparam int S_TUSER_W  = 2;
    localparam int S_TDATA_W  = 56;
    localparam int S_REQ_KIND_LO    = 0;
    localparam int S_REQ_NODE_LO    = 3;
    localparam int S_REPLY_KIND_LO  = 11;
    localparam int S_REPLY_NODE_LO  = 14;
    localparam int S_REPLY_VALUE_LO = 22;

    // result item fields
    localparam int M_TDATA_W     = 120;
    localparam int M_SENT        = 0;
    localparam int M_SENT_KIND_LO = 1;
    localparam int M_SENT_NODE_LO = 4;
    localparam int M_TIMED_OUT   = 12;
    localparam int M_DROPPED     = 13;
    localparam int M_WAITING     = 14;
    localparam int M_ALIVE_LO    = 15;
    localparam int M_COMPASS_LO  = 23;
    localparam int M_BATTERY_LO  = 39;
    localparam int M_LAT_LO      = 55;
    localparam int M_LON_LO      = 87;
    localparam int M_USED_W      = 119;

    typedef struct packed {
        logic step;
        logic send;
        logic timeout;
        logic decr;
        logic enq;
        logic drop;
        logic reply;
    } cmd_t;

    typedef struct packed {
        logic q_empty;
        logic q_full;
        logic waiting;
        logic cd_neg;
    } status_t;

endpackage

>>> rtl/core/sawrq_ctrl.sv
// sawrq_ctrl: handshake state machine and action decode for the request queue.
// Depends on sawrq_pkg; drives commands into sawrq_datapath.
`timescale 1ns / 1ps

module sawrq_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sawrq_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  sawrq_pkg::status_t                  status,
    output sawrq_pkg::cmd_t                     cmd
);
    import sawrq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    action_t act;
    logic    accept;
    logic    tick_busy;

    assign act      = action_t'(s_tuser);
    // a held result that is taken this cycle frees the output register
    assign s_tready = (state_reg == ST_IDLE) || m_tready;
    assign m_tvalid = (state_reg == ST_HOLD);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!accept && m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ticks only act while something is queued
    assign tick_busy = accept && (act == ACT_TICK) && !status.q_empty;

    always_comb begin
        cmd         = '0;
        cmd.step    = accept;
        cmd.send    = tick_busy && !status.waiting;
        cmd.timeout = tick_busy && status.waiting && status.cd_neg;
        cmd.decr    = tick_busy && status.waiting && !status.cd_neg;
        cmd.enq     = accept && (act == ACT_ENQ) && !status.q_full;
        cmd.drop    = accept && (act == ACT_ENQ) && status.q_full;
        cmd.reply   = accept && (act == ACT_REPLY);
    end

endmodule

>>> rtl/core/sawrq_datapath.sv
// sawrq_datapath: request store, queue pointers, wait timer, node alive map,
// telemetry registers and the result register. Depends on sawrq_pkg.
`timescale 1ns / 1ps

module sawrq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sawrq_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                cfg_we,
    input  logic [sawrq_pkg::TIMEOUT_W-1:0]     cfg_wdata,
    input  sawrq_pkg::cmd_t                     cmd,
    output sawrq_pkg::status_t                  status,
    output logic [sawrq_pkg::M_TDATA_W-1:0]     m_tdata
);
    import sawrq_pkg::*;

    logic [ENTRY_W-1:0]   store_mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0]    send_reg, send_next;
    logic [QIDX_W-1:0]    fill_reg, fill_next;
    logic [QIDX_W-1:0]    fill_inc, send_inc;
    logic                 wait_reg, wait_next;
    logic [CD_W-1:0]      cd_reg, cd_next;
    logic [NODE_W-1:0]    pend_reg, pend_next;
    logic [NODE_COUNT-1:0] alive_reg, alive_next;
    logic [HALF_W-1:0]    compass_reg, compass_next;
    logic [HALF_W-1:0]    battery_reg, battery_next;
    logic [VALUE_W-1:0]   lat_reg, lat_next;
    logic [VALUE_W-1:0]   lon_reg, lon_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [KIND_W-1:0]    req_kind, reply_kind;
    logic [NODE_W-1:0]    req_node, reply_node;
    logic [VALUE_W-1:0]   reply_value;
    logic [ENTRY_W-1:0]   head_entry;

    assign req_kind    = s_tdata[S_REQ_KIND_LO +: KIND_W];
    assign req_node    = s_tdata[S_REQ_NODE_LO +: NODE_W];
    assign reply_kind  = s_tdata[S_REPLY_KIND_LO +: KIND_W];
    assign reply_node  = s_tdata[S_REPLY_NODE_LO +: NODE_W];
    assign reply_value = s_tdata[S_REPLY_VALUE_LO +: VALUE_W];

    assign fill_inc = (fill_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : fill_reg + 1'b1;
    assign send_inc = (send_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : send_reg + 1'b1;
    assign head_entry = store_mem[send_reg];

    assign status.q_empty = (send_reg == fill_reg);
    assign status.q_full  = (fill_inc == send_reg);
    assign status.waiting = wait_reg;
    assign status.cd_neg  = cd_reg[CD_W-1];

    always_comb begin
        send_next    = send_reg;
        fill_next    = fill_reg;
        wait_next    = wait_reg;
        cd_next      = cd_reg;
        pend_next    = pend_reg;
        alive_next   = alive_reg;
        compass_next = compass_reg;
        battery_next = battery_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;

        if (cmd.send) begin
            pend_next = head_entry[NODE_W-1:0];
            send_next = send_inc;
            wait_next = 1'b1;
            cd_next   = CD_W'(timeout_reg);
        end
        if (cmd.timeout) begin
            wait_next = 1'b0;
            cd_next   = AFTER_TIMEOUT;
            // nodes past the alive map have no bit to clear
            for (int i = 0; i < NODE_COUNT; i++) begin
                if (pend_reg == NODE_W'(i)) alive_next[i] = 1'b0;
            end
        end
        if (cmd.decr) begin
            cd_next = cd_reg - 1'b1;
        end
        if (cmd.enq) begin
            fill_next = fill_inc;
        end
        if (cmd.reply) begin
            wait_next = 1'b0;
            case (reply_kind)
                KIND_HEARTBEAT: begin
                    for (int i = 0; i < NODE_COUNT; i++) begin
                        if (reply_node == NODE_W'(i)) alive_next[i] = 1'b1;
                    end
                end
                KIND_COMPASS:   compass_next = reply_value[HALF_W-1:0];
                KIND_BATTERY:   battery_next = reply_value[HALF_W-1:0];
                KIND_LATITUDE:  lat_next     = reply_value;
                KIND_LONGITUDE: lon_next     = reply_value;
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next = '0;
        out_next[M_SENT]        = cmd.send;
        if (cmd.send) begin
            out_next[M_SENT_KIND_LO +: KIND_W] = head_entry[ENTRY_W-1:NODE_W];
            out_next[M_SENT_NODE_LO +: NODE_W] = head_entry[NODE_W-1:0];
        end
        out_next[M_TIMED_OUT]   = cmd.timeout;
        out_next[M_DROPPED]     = cmd.drop;
        out_next[M_WAITING]     = wait_next;
        out_next[M_ALIVE_LO +: ALIVE_OUT_W] = ALIVE_OUT_W'(alive_next);
        out_next[M_COMPASS_LO +: HALF_W]    = compass_next;
        out_next[M_BATTERY_LO +: HALF_W]    = battery_next;
        out_next[M_LAT_LO +: VALUE_W]       = lat_next;
        out_next[M_LON_LO +: VALUE_W]       = lon_next;
    end

    // store entries hold no reset; only queued entries are ever read
    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            store_mem[fill_reg] <= {req_kind, req_node};
        end
        if (cmd.step) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_reg    <= '0;
            fill_reg    <= '0;
            wait_reg    <= 1'b0;
            cd_reg      <= '0;
            pend_reg    <= '0;
            alive_reg   <= '0;
            compass_reg <= '0;
            battery_reg <= '0;
            lat_reg     <= '0;
            lon_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            if (cmd.step) begin
                send_reg    <= send_next;
                fill_reg    <= fill_next;
                wait_reg    <= wait_next;
                cd_reg      <= cd_next;
                pend_reg    <= pend_next;
                alive_reg   <= alive_next;
                compass_reg <= compass_next;
                battery_reg <= battery_next;
                lat_reg     <= lat_next;
                lon_reg     <= lon_next;
            end
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

>>> rtl/core/stop_and_wait_request_queue_unit.sv
// stop_and_wait_request_queue_unit: top level of the stop-and-wait request queue.
// Each accepted item's result is registered in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while m_tready is high; s_tready stays high while the held result is taken.
// Each item is applied in its accept cycle by the datapath's update.
// Reset (aresetn low, synchronous) empties the queue, clears wait, timer, alive map
// and telemetry registers, and loads the timeout register with 5000.
`timescale 1ns / 1ps

module stop_and_wait_request_queue_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sawrq_pkg::TIMEOUT_W-1:0]     cfg_wdata,   // timeout_ticks
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sawrq_pkg::S_TUSER_W-1:0]     s_tuser,     // action
    // req_kind, req_node, reply_kind, reply_node, reply_value, zero pad
    input  logic [sawrq_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sent, sent_kind, sent_node, timed_out, dropped, waiting, alive_map,
    // compass, battery, latitude, longitude, zero pad
    output logic [sawrq_pkg::M_TDATA_W-1:0]     m_tdata
);
    import sawrq_pkg::*;

    cmd_t    cmd;
    status_t status;

    sawrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sawrq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

    // every accepted item leaves a result behind
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // a send and a timeout never come from the same tick
    a_send_xor_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_SENT] && m_tdata[M_TIMED_OUT]))
        else $error("send and timeout in one result");

    // a send always starts a wait
    a_send_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_SENT] |-> m_tdata[M_WAITING])
        else $error("request sent without waiting");

    // the queue cannot look empty and full at once
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.q_empty && status.q_full))
        else $error("queue both empty and full");

endmodule

>>> sim/stop_and_wait_request_queue_unit_tb.sv
// Self-checking bench for stop_and_wait_request_queue_unit: a clocked driver and
// monitor around an in-bench model of the queue, timer, alive map and telemetry.
// Depends on sawrq_pkg and the unit RTL only.
`timescale 1ns / 1ps

module stop_and_wait_request_queue_unit_tb;
    import sawrq_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 170;

    typedef struct packed {
        action_t             action;
        logic [KIND_W-1:0]   req_kind;
        logic [NODE_W-1:0]   req_node;
        logic [KIND_W-1:0]   reply_kind;
        logic [NODE_W-1:0]   reply_node;
        logic [VALUE_W-1:0]  reply_value;
    } unit_item_t;

    typedef struct packed {
        logic                   sent;
        logic [KIND_W-1:0]      sent_kind;
        logic [NODE_W-1:0]      sent_node;
        logic                   timed_out;
        logic                   dropped;
        logic                   waiting;
        logic [ALIVE_OUT_W-1:0] alive;
        logic [HALF_W-1:0]      compass;
        logic [HALF_W-1:0]      battery;
        logic [VALUE_W-1:0]     latitude;
        logic [VALUE_W-1:0]     longitude;
    } queue_report_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [TIMEOUT_W-1:0]   cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    stop_and_wait_request_queue_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model state of the unit
    logic [ENTRY_W-1:0]     q_store [QUEUE_DEPTH];
    logic [QIDX_W-1:0]      q_head = '0;
    logic [QIDX_W-1:0]      q_tail = '0;
    logic                   q_wait = 1'b0;
    logic signed [CD_W-1:0] q_timer = '0;
    logic [NODE_W-1:0]      q_pending_node = '0;
    logic [ALIVE_OUT_W-1:0] q_alive = '0;
    logic [HALF_W-1:0]      q_compass = '0;
    logic [HALF_W-1:0]      q_battery = '0;
    logic [VALUE_W-1:0]     q_lat = '0;
    logic [VALUE_W-1:0]     q_lon = '0;
    logic [TIMEOUT_W-1:0]   q_timeout = TIMEOUT_RESET;

    unit_item_t    pending_items [$];
    queue_report_t reports_owed [$];
    unit_item_t    cur_item;
    queue_report_t want_report;

    int errors = 0;
    int reports_taken = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit [31:0] rx_cycle = '0;
    int idle_cycles = 0;

    function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] i);
        if (i == QIDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return i + 1'b1;
        end
    endfunction

    function automatic logic [ALIVE_OUT_W-1:0] node_mask(input logic [NODE_W-1:0] node);
        if (node < NODE_COUNT) begin
            return ALIVE_OUT_W'(1) << node;
        end else begin
            return '0;
        end
    endfunction

    function automatic queue_report_t step_request_queue(input unit_item_t it);
        queue_report_t r;
        logic [QIDX_W-1:0] nf;
        logic [ENTRY_W-1:0] e;
        r = '0;
        case (it.action)
            ACT_TICK: begin
                if (q_head != q_tail) begin
                    if (!q_wait) begin
                        e = q_store[q_head];
                        r.sent = 1'b1;
                        r.sent_kind = e[ENTRY_W-1:NODE_W];
                        r.sent_node = e[NODE_W-1:0];
                        q_pending_node = e[NODE_W-1:0];
                        q_head = next_slot(q_head);
                        q_wait = 1'b1;
                        q_timer = $signed({1'b0, q_timeout});
                    end else if (q_timer < 0) begin
                        r.timed_out = 1'b1;
                        q_wait = 1'b0;
                        q_timer = AFTER_TIMEOUT;
                        q_alive = q_alive & ~node_mask(q_pending_node);
                    end else begin
                        q_timer = q_timer - CD_W'(1);
                    end
                end
            end
            ACT_ENQ: begin
                nf = next_slot(q_tail);
                if (nf == q_head) begin
                    r.dropped = 1'b1;
                end else begin
                    q_store[q_tail] = {it.req_kind, it.req_node};
                    q_tail = nf;
                end
            end
            ACT_REPLY: begin
                case (it.reply_kind)
                    KIND_HEARTBEAT: q_alive = q_alive | node_mask(it.reply_node);
                    KIND_COMPASS:   q_compass = it.reply_value[HALF_W-1:0];
                    KIND_BATTERY:   q_battery = it.reply_value[HALF_W-1:0];
                    KIND_LATITUDE:  q_lat = it.reply_value;
                    KIND_LONGITUDE: q_lon = it.reply_value;
                    default: ;
                endcase
                q_wait = 1'b0;
            end
            default: ;
        endcase
        r.waiting = q_wait;
        r.alive = q_alive;
        r.compass = q_compass;
        r.battery = q_battery;
        r.latitude = q_lat;
        r.longitude = q_lon;
        return r;
    endfunction

    function automatic logic [NODE_W-1:0] random_node();
        if ($urandom_range(0, 9) < 7) begin
            return NODE_W'($urandom_range(0, NODE_COUNT - 1));
        end else begin
            return NODE_W'($urandom_range(0, 255));
        end
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        if ($urandom_range(0, 9) < 8) begin
            return KIND_W'($urandom_range(0, 4));
        end else begin
            return KIND_W'($urandom_range(5, 7));
        end
    endfunction

    // mostly ticks and enqueues so the queue fills and the timer runs out
    function automatic unit_item_t random_item(input int reply_pct);
        unit_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.action = ACT_NONE;
        end else if (pick < 4 + reply_pct) begin
            it.action = ACT_REPLY;
        end else if (pick < 32 + reply_pct) begin
            it.action = ACT_ENQ;
        end else begin
            it.action = ACT_TICK;
        end
        it.req_kind = random_kind();
        it.req_node = random_node();
        it.reply_kind = random_kind();
        it.reply_node = random_node();
        it.reply_value = $urandom;
        return it;
    endfunction

    task automatic add_item(input action_t a, input logic [KIND_W-1:0] k,
                            input logic [NODE_W-1:0] n, input logic [KIND_W-1:0] rk,
                            input logic [NODE_W-1:0] rn, input logic [VALUE_W-1:0] v);
        unit_item_t it;
        it.action = a;
        it.req_kind = k;
        it.req_node = n;
        it.reply_kind = rk;
        it.reply_node = rn;
        it.reply_value = v;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || reports_owed.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        q_timeout = value;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            if (errors < 40) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
            errors++;
        end
    endtask

    // driver: bursts of items with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reports_owed.push_back(step_request_queue(cur_item));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    s_tuser <= cur_item.action;
                    s_tdata <= {2'b00, cur_item.reply_value, cur_item.reply_node,
                                cur_item.reply_kind, cur_item.req_node, cur_item.req_kind};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4: gap_left = 0;
                            5, 6, 7:       gap_left = $urandom_range(10, 30);
                            default:       gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end
            end
        end
    end

    // receiver: stall pattern follows rx_cycle[8:6], plus one long hold-off
    always @(posedge aclk) begin
        rx_cycle = rx_cycle + 1;
        if (!hold_done && reports_taken >= 300) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_cycle[8:6])
                3'd2:    m_tready <= 1'($urandom_range(0, 1));
                3'd3:    m_tready <= (rx_cycle[1:0] != 2'b00);
                3'd4:    m_tready <= (rx_cycle[2:0] == 3'b000);
                3'd5:    m_tready <= ($urandom_range(0, 3) != 0);
                3'd7:    m_tready <= rx_cycle[4];
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // monitor: compare each result with the oldest owed report
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reports_taken++;
            if (reports_owed.size() == 0) begin
                if (errors < 40) begin
                    $display("%0t: result with nothing owed, expected none, got %h",
                             $time, m_tdata);
                end
                errors++;
            end else begin
                want_report = reports_owed.pop_front();
                check_field("sent", want_report.sent, m_tdata[M_SENT]);
                check_field("sent_kind", want_report.sent_kind,
                            m_tdata[M_SENT_KIND_LO +: KIND_W]);
                check_field("sent_node", want_report.sent_node,
                            m_tdata[M_SENT_NODE_LO +: NODE_W]);
                check_field("timed_out", want_report.timed_out, m_tdata[M_TIMED_OUT]);
                check_field("dropped", want_report.dropped, m_tdata[M_DROPPED]);
                check_field("waiting", want_report.waiting, m_tdata[M_WAITING]);
                check_field("alive_map", want_report.alive,
                            m_tdata[M_ALIVE_LO +: ALIVE_OUT_W]);
                check_field("compass", want_report.compass, m_tdata[M_COMPASS_LO +: HALF_W]);
                check_field("battery", want_report.battery, m_tdata[M_BATTERY_LO +: HALF_W]);
                check_field("latitude", want_report.latitude, m_tdata[M_LAT_LO +: VALUE_W]);
                check_field("longitude", want_report.longitude,
                            m_tdata[M_LON_LO +: VALUE_W]);
                check_field("pad", '0, m_tdata[M_TDATA_W-1:M_USED_W]);
            end
        end
    end

    // watchdog on handshake progress while work is outstanding
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (pending_items.size() != 0 || s_tvalid || reports_owed.size() != 0) begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [TIMEOUT_W-1:0] tmo;
        int reply_pct;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset timeout: idle action, empty tick, every reply kind, fill to overflow
        add_item(ACT_NONE, 3'd7, 8'hFF, 3'd7, 8'hFF, 32'hFFFF_FFFF);
        add_item(ACT_TICK, 3'd0, 8'h00, 3'd0, 8'h00, 32'h0);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_HEARTBEAT, 8'd0, 32'h0);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_HEARTBEAT, 8'd7, 32'h0);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_HEARTBEAT, 8'd8, 32'h0);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_COMPASS, 8'd1, 32'h1234_8001);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_BATTERY, 8'd2, 32'hABCD_7FFF);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_LATITUDE, 8'd3, 32'h8000_0000);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_LONGITUDE, 8'd4, 32'h7FFF_FFFF);
        add_item(ACT_REPLY, 3'd0, 8'h00, 3'd5, 8'd3, 32'h5A5A_A5A5);
        add_item(ACT_ENQ, KIND_HEARTBEAT, 8'd0, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, KIND_COMPASS, 8'd255, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, KIND_BATTERY, 8'd8, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, KIND_LATITUDE, 8'd7, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, KIND_LONGITUDE, 8'd1, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, 3'd5, 8'd2, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, 3'd7, 8'd3, 3'd0, 8'h00, 32'h0);
        add_item(ACT_ENQ, 3'd6, 8'd4, 3'd0, 8'h00, 32'h0);
        add_item(ACT_TICK, 3'd0, 8'h00, 3'd0, 8'h00, 32'h0);
        add_item(ACT_TICK, 3'd0, 8'h00, 3'd0, 8'h00, 32'h0);
        add_item(ACT_REPLY, 3'd0, 8'h00, 3'd7, 8'd255, 32'h0);
        add_item(ACT_TICK, 3'd0, 8'h00, 3'd0, 8'h00, 32'h0);

        // zero timeout: timeouts on a node outside the map and on node 7
        write_timeout('0);
        add_item(ACT_REPLY, 3'd0, 8'h00, KIND_HEARTBEAT, 8'd7, 32'h0);
        repeat (2) begin
            repeat (3) add_item(ACT_TICK, 3'd0, 8'h00, 3'd0, 8'h00, 32'h0);
        end

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       tmo = 14'd3;
                1:       tmo = '1;
                2:       tmo = TIMEOUT_W'($urandom_range(4, 15));
                3:       tmo = 14'd1;
                default: tmo = '0;
            endcase
            write_timeout(tmo);
            reply_pct = (tmo < 8) ? 20 : 8;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                pending_items.push_back(random_item(reply_pct));
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (reports_owed.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
